FILE: rtl/core/fmep_pkg.sv
// ----------------------------------------------------------------------------
// fmep_pkg - shared types and constants of the first-match event policy
// Codes, field layouts of the stream words and the stored rule format.
// ----------------------------------------------------------------------------
package fmep_pkg;

	// rule table size
	localparam int MAX_RULES = 16;
	localparam int AW        = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
	localparam int CW        = $clog2(MAX_RULES + 1);

	// item kinds (s_tuser)
	localparam logic [1:0] KIND_DECIDE = 2'd0;
	localparam logic [1:0] KIND_ADD    = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	// configuration register indexes
	localparam logic [0:0] CFG_PROFILE = 1'd0;
	localparam logic [0:0] CFG_SEALED  = 1'd1;

	// profiles
	localparam logic [1:0] PROF_TRACE  = 2'd0;
	localparam logic [1:0] PROF_AUTO   = 2'd1;
	localparam logic [1:0] PROF_EXPERT = 2'd2;

	// event codes
	localparam logic [3:0] EV_WRITE  = 4'd8;
	localparam logic [3:0] EV_IOCTL  = 4'd9;
	localparam logic [3:0] EV_SG     = 4'd10;
	localparam logic [3:0] EV_REBOOT = 4'd11;
	localparam logic [3:0] EV_ANY    = 4'd15;

	localparam logic [63:0] ANY_BOUND = '1;
	localparam logic [15:0] DEV_ANY   = 16'd0;

	// actions
	localparam logic [2:0] ACT_PASS     = 3'd0;
	localparam logic [2:0] ACT_SIMULATE = 3'd1;
	localparam logic [2:0] ACT_DENY     = 3'd2;
	localparam logic [2:0] ACT_SUPPRESS = 3'd4;

	// reason codes
	localparam logic [2:0] RSN_UNSEALED_DENY   = 3'd0;
	localparam logic [2:0] RSN_UNSEALED_REBOOT = 3'd1;
	localparam logic [2:0] RSN_UNSEALED_PASS   = 3'd2;
	localparam logic [2:0] RSN_TRACE           = 3'd3;
	localparam logic [2:0] RSN_RULE            = 3'd4;
	localparam logic [2:0] RSN_REBOOT          = 3'd5;
	localparam logic [2:0] RSN_DANGEROUS       = 3'd6;
	localparam logic [2:0] RSN_ORDINARY        = 3'd7;

	// add status
	localparam logic [1:0] ADD_OK         = 2'd0;
	localparam logic [1:0] ADD_SEALED     = 2'd1;
	localparam logic [1:0] ADD_NOT_EXPERT = 2'd2;
	localparam logic [1:0] ADD_FULL       = 2'd3;

	// input word, first field in the highest bits
	typedef struct packed {
		logic [31:0] rule_wait;
		logic [63:0] rule_ret_val;
		logic [2:0]  rule_action;
		logic [63:0] length_or_end;
		logic [63:0] offset;
		logic [15:0] device_id;
		logic        lineage_flag;
		logic [3:0]  evt_code;
	} in_word_t;

	localparam int IN_TDATA_W = $bits(in_word_t);

	// result, first field in the highest bits
	typedef struct packed {
		logic [1:0]  add_status;
		logic [2:0]  reason_code;
		logic        terminal;
		logic [31:0] hold_ms;
		logic [63:0] ret_val;
		logic [2:0]  action;
	} res_t;

	localparam int RES_W       = $bits(res_t);
	localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

	// event as seen by the compare unit
	typedef struct packed {
		logic [3:0]  evt_code;
		logic        lineage_flag;
		logic [15:0] device_id;
		logic [63:0] offset;
		logic [63:0] length;
	} ev_t;

	// one stored rule
	typedef struct packed {
		logic [15:0] device;
		logic        lineage;
		logic [3:0]  rtype;
		logic [63:0] range_begin;
		logic [63:0] range_end;
		logic [2:0]  verdict;
		logic [63:0] result_value;
		logic [31:0] wait_ms;
	} rule_t;

	localparam int RULE_W = $bits(rule_t);

endpackage

FILE: rtl/core/fmep_ram.sv
// ----------------------------------------------------------------------------
// fmep_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents undefined at reset.
// ----------------------------------------------------------------------------
module fmep_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/core/fmep_match.sv
// ----------------------------------------------------------------------------
// fmep_match - rule compare unit
// Checks one stored rule against the held event: type, lineage, device and
// offset range. Shared over all rules by the scan sequencer.
// ----------------------------------------------------------------------------
module fmep_match (
	input  fmep_pkg::rule_t rule,
	input  fmep_pkg::ev_t   ev,
	output logic            hit
);

	logic type_ok;
	logic lin_ok;
	logic dev_ok;
	logic lo_ok;
	logic hi_ok;

	// field checks; all-ones bound means unbounded
	always_comb begin
		type_ok = (rule.rtype == fmep_pkg::EV_ANY) || (rule.rtype == ev.evt_code);
		lin_ok  = !rule.lineage || ev.lineage_flag;
		dev_ok  = (rule.device == fmep_pkg::DEV_ANY) || (rule.device == ev.device_id);
		lo_ok   = (rule.range_begin == fmep_pkg::ANY_BOUND) ||
			(ev.offset >= rule.range_begin);
		hi_ok   = (rule.range_end == fmep_pkg::ANY_BOUND) ||
			(ev.offset <= rule.range_end);
		hit     = type_ok && lin_ok && dev_ok && lo_ok && hi_ok;
	end

endmodule

FILE: rtl/core/first_match_event_policy.sv
// ----------------------------------------------------------------------------
// first_match_event_policy - first-match event policy engine
// Rule table loaded by add words; decide words are answered by the policy.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one input word per item: s_tuser is the kind (decide, add,
//   clear), s_tdata the event or rule fields. m_* returns one result word per
//   item. cfg_* writes profile (index 0) and sealed (index 1); cfg_ready is
//   always high, and writes are meant to happen while the block is idle.
// Scan:
//   a word without a rule scan passes the done state into the output register.
//   A sealed expert decide with rules stored scans the table through one
//   compare unit, one rule a cycle fed from the registered RAM read, and stops
//   at the first hit or after the last stored rule.
// Flow:
//   one item at a time: s_tready is high only in idle, so no new word is
//   taken before the last one has left the sequencer. The output register
//   lets the next word be accepted while a result waits.
// Reset:
//   arst_n clears the rule count, sets profile to auto and unseals. The rule
//   RAM is not cleared; only entries below the rule count are ever read.
// Stall:
//   while m_tready is low the result holds and a finished item waits in the
//   sequencer; no input word is taken meanwhile.
// ----------------------------------------------------------------------------
module first_match_event_policy (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// evt_code, lineage_flag, device_id, offset, length_or_end,
	// rule_action, rule_ret_val, rule_wait
	input  logic [fmep_pkg::IN_TDATA_W-1:0]      s_tdata,
	// kind
	input  logic [1:0]                           s_tuser,
	// result stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// action, ret_val, hold_ms, terminal, reason_code, add_status, pad
	output logic [fmep_pkg::OUT_TDATA_W-1:0]     m_tdata,
	// configuration write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [0:0]                           cfg_index,
	input  logic [1:0]                           cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t                    state_q;
	logic [1:0]                profile_q;
	logic                      sealed_q;
	logic [fmep_pkg::CW-1:0]   count_q;
	logic [fmep_pkg::CW-1:0]   rd_idx_q;
	logic                      cmp_vld_s1;
	logic                      cmp_last_s1;
	logic                      m_tvalid_q;
	fmep_pkg::ev_t             ev_q;
	fmep_pkg::res_t            pend_q;
	fmep_pkg::res_t            out_q;

	fmep_pkg::in_word_t        in_w;
	fmep_pkg::rule_t           new_rule;
	fmep_pkg::rule_t           rd_rule;
	fmep_pkg::res_t            res_now;
	logic [1:0]                add_st;
	logic                      accept;
	logic                      add_we;
	logic                      need_scan;
	logic                      issue;
	logic                      hit;
	logic                      out_free;

	// default outcome once no rule applies
	function automatic fmep_pkg::res_t dflt_res(logic [3:0] t, logic [63:0] len);
		fmep_pkg::res_t r;
		r = '0;
		if (t == fmep_pkg::EV_REBOOT) begin
			r.action      = fmep_pkg::ACT_SUPPRESS;
			r.terminal    = 1'b1;
			r.reason_code = fmep_pkg::RSN_REBOOT;
		end else if (t == fmep_pkg::EV_WRITE || t == fmep_pkg::EV_IOCTL ||
			t == fmep_pkg::EV_SG) begin
			r.action      = fmep_pkg::ACT_SIMULATE;
			r.ret_val     = (t == fmep_pkg::EV_WRITE) ? len : 64'd0;
			r.reason_code = fmep_pkg::RSN_DANGEROUS;
		end else begin
			r.action      = fmep_pkg::ACT_PASS;
			r.reason_code = fmep_pkg::RSN_ORDINARY;
		end
		return r;
	endfunction

	// outcome handed back by a matching rule
	function automatic fmep_pkg::res_t rule_res(fmep_pkg::rule_t ru);
		fmep_pkg::res_t r;
		r             = '0;
		r.action      = ru.verdict;
		r.ret_val     = ru.result_value;
		r.hold_ms     = ru.wait_ms;
		r.terminal    = (ru.verdict == fmep_pkg::ACT_SUPPRESS);
		r.reason_code = fmep_pkg::RSN_RULE;
		return r;
	endfunction

	assign in_w      = fmep_pkg::in_word_t'(s_tdata);
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {{(fmep_pkg::OUT_TDATA_W - fmep_pkg::RES_W){1'b0}}, out_q};
	assign out_free  = !m_tvalid_q || m_tready;
	assign issue     = (state_q == ST_SCAN) && (rd_idx_q < count_q);

	// rule word built from an add
	always_comb begin
		new_rule              = '0;
		new_rule.rtype        = in_w.evt_code;
		new_rule.lineage      = in_w.lineage_flag;
		new_rule.device       = in_w.device_id;
		new_rule.range_begin  = in_w.offset;
		new_rule.range_end    = in_w.length_or_end;
		new_rule.verdict      = in_w.rule_action;
		new_rule.result_value = in_w.rule_ret_val;
		new_rule.wait_ms      = in_w.rule_wait;
	end

	// add status and immediate outcome of the accepted word
	always_comb begin
		if (sealed_q) begin
			add_st = fmep_pkg::ADD_SEALED;
		end else if (profile_q != fmep_pkg::PROF_EXPERT) begin
			add_st = fmep_pkg::ADD_NOT_EXPERT;
		end else if (count_q >= fmep_pkg::CW'(fmep_pkg::MAX_RULES)) begin
			add_st = fmep_pkg::ADD_FULL;
		end else begin
			add_st = fmep_pkg::ADD_OK;
		end
		add_we    = accept && (s_tuser == fmep_pkg::KIND_ADD) && (add_st == fmep_pkg::ADD_OK);
		res_now   = '0;
		need_scan = 1'b0;
		unique case (s_tuser)
			fmep_pkg::KIND_ADD: begin
				res_now.add_status = add_st;
			end
			fmep_pkg::KIND_DECIDE: begin
				priority if (!sealed_q) begin
					if (in_w.evt_code == fmep_pkg::EV_WRITE ||
						in_w.evt_code == fmep_pkg::EV_IOCTL ||
						in_w.evt_code == fmep_pkg::EV_SG) begin
						res_now.action      = fmep_pkg::ACT_DENY;
						res_now.ret_val     = '1;
						res_now.reason_code = fmep_pkg::RSN_UNSEALED_DENY;
					end else if (in_w.evt_code == fmep_pkg::EV_REBOOT) begin
						res_now.action      = fmep_pkg::ACT_SUPPRESS;
						res_now.terminal    = 1'b1;
						res_now.reason_code = fmep_pkg::RSN_UNSEALED_REBOOT;
					end else begin
						res_now.reason_code = fmep_pkg::RSN_UNSEALED_PASS;
					end
				end else if (profile_q == fmep_pkg::PROF_TRACE) begin
					res_now.reason_code = fmep_pkg::RSN_TRACE;
				end else if (profile_q == fmep_pkg::PROF_EXPERT && count_q != '0) begin
					need_scan = 1'b1;
				end else begin
					res_now = dflt_res(in_w.evt_code, in_w.length_or_end);
				end
			end
			default: begin
				res_now = '0;
			end
		endcase
	end

	// rule table
	fmep_ram #(
		.WIDTH(fmep_pkg::RULE_W),
		.DEPTH(fmep_pkg::MAX_RULES)
	) u_rules (
		.clk  (clk),
		.we   (add_we),
		.waddr(count_q[fmep_pkg::AW-1:0]),
		.wdata(new_rule),
		.re   (issue),
		.raddr(rd_idx_q[fmep_pkg::AW-1:0]),
		.rdata(rd_rule)
	);

	// shared rule compare
	fmep_match u_match (
		.rule(rd_rule),
		.ev  (ev_q),
		.hit (hit)
	);

	// sequencer, configuration and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			profile_q  <= fmep_pkg::PROF_AUTO;
			sealed_q   <= 1'b0;
			count_q    <= '0;
			rd_idx_q   <= '0;
			cmp_vld_s1 <= 1'b0;
			m_tvalid_q <= 1'b0;
			out_q      <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					fmep_pkg::CFG_PROFILE: profile_q <= cfg_data;
					fmep_pkg::CFG_SEALED:  sealed_q  <= cfg_data[0];
					default: ;
				endcase
			end
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
				out_q      <= pend_q;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser == fmep_pkg::KIND_CLEAR) begin
							count_q <= '0;
						end else if (add_we) begin
							count_q <= count_q + 1'b1;
						end
						rd_idx_q   <= '0;
						cmp_vld_s1 <= 1'b0;
						state_q    <= need_scan ? ST_SCAN : ST_DONE;
					end
				end
				ST_SCAN: begin
					rd_idx_q   <= rd_idx_q + fmep_pkg::CW'(issue);
					cmp_vld_s1 <= issue;
					if (cmp_vld_s1 && (hit || cmp_last_s1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload: held event and pending result
	always_ff @(posedge clk) begin
		if (accept) begin
			ev_q.evt_code     <= in_w.evt_code;
			ev_q.lineage_flag <= in_w.lineage_flag;
			ev_q.device_id    <= in_w.device_id;
			ev_q.offset       <= in_w.offset;
			ev_q.length       <= in_w.length_or_end;
			pend_q            <= res_now;
		end
		if (state_q == ST_SCAN) begin
			cmp_last_s1 <= ((rd_idx_q + 1'b1) == count_q);
			if (cmp_vld_s1) begin
				if (hit) begin
					pend_q <= rule_res(rd_rule);
				end else if (cmp_last_s1) begin
					pend_q <= dflt_res(ev_q.evt_code, ev_q.length);
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_terminal_matches_action: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (out_q.terminal == (out_q.action == fmep_pkg::ACT_SUPPRESS)))
		else $error("terminal flag disagrees with action");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= fmep_pkg::CW'(fmep_pkg::MAX_RULES))
		else $error("rule count beyond table size");

	a_add_counts: assert property (@(posedge clk) disable iff (!arst_n)
		add_we |=> (count_q == $past(count_q) + 1'b1))
		else $error("accepted add did not advance rule count");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> ((rd_idx_q <= count_q) && (count_q != '0)))
		else $error("scan index outside rule table");
`endif

endmodule
